// ===== rtl/core/wse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wse_pkg
// Shared constants and types for the wiggle sort engine.
// ----------------------------------------------------------------------------
package wse_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,   // loading, accepting requests
        S_SEG,    // set up one merge segment
        S_MRD,    // read heads of both runs
        S_MCMP,   // compare heads, write winner
        S_OINIT,  // set up output pointers
        S_ORD,    // read next output element
        S_OEMIT   // present result for one cycle
    } t_state;

endpackage : wse_pkg
`default_nettype wire

// ===== rtl/core/wiggle_sort_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wiggle_sort_engine
// Collects a set of signed values, sorts them, emits them in wiggle order.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/busy: a request is taken on a rising edge with
//   start high and busy low. Each request carries one signed value; the one
//   with i_end_of_set high closes the set. Up to MAX_ELEMENTS values are
//   held; further ones are dropped and every result of that set then shows
//   o_overflow.
//   Loading leaves busy low. The closing request raises busy while a
//   bottom-up merge sort ping-pongs between two RAMs through one shared
//   compare unit: for each element of each pass it reads both run heads,
//   then compares and writes, over ceil(log2(n)) passes; each merge segment
//   (n-1 over all passes for a power-of-two n) starts with a set-up step.
//   The n results then follow (read, then present), each on the o_* result
//   ports for exactly one cycle marked by o_strobe; the last carries
//   o_end_of_set_res. Busy drops in the cycle after it.
//   The receiver cannot stall: results are never held back.
//   Reset (i_rst_n low, synchronous) empties the set and clears overflow;
//   RAM contents are not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
module wiggle_sort_engine
    import wse_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_end_of_set,
    output logic                    o_strobe,
    output logic signed [31:0]      o_value_res,
    output logic                    o_end_of_set_res,
    output logic                    o_overflow
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);   // element count
    localparam int PW = CW + 2;                     // pointers, room for lo + 2*width

    // ---- state ----
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;    // elements held
    logic            r_ovf,   n_ovf;      // a value was dropped
    logic            r_sel,   n_sel;      // 0: source is RAM 0, 1: source is RAM 1
    logic [PW-1:0]   r_w,     n_w;        // run width of the current pass
    logic [PW-1:0]   r_lo,    n_lo;       // segment start
    logic [PW-1:0]   r_mid,   n_mid;      // end of run a / start of run b
    logic [PW-1:0]   r_hi,    n_hi;       // segment end
    logic [PW-1:0]   r_a,     n_a;        // run a pointer, or lower-half index
    logic [PW-1:0]   r_b,     n_b;        // run b pointer, or upper-half index
    logic [PW-1:0]   r_k,     n_k;        // write pointer, or output position

    // ---- RAM ports ----
    logic                 ram0_we, ram1_we;
    logic [AW-1:0]        ram0_waddr, ram1_waddr;
    logic [DATA_W-1:0]    ram0_wdata, ram1_wdata;
    logic [AW-1:0]        raddr_a, raddr_b;
    logic [DATA_W-1:0]    ram0_rd_a, ram0_rd_b, ram1_rd_a, ram1_rd_b;
    logic signed [DATA_W-1:0] src_a, src_b;

    // ---- helpers ----
    logic            accept;
    logic            full;
    logic [CW-1:0]   cnt_after;
    logic [PW-1:0]   n_ext;
    logic [PW-1:0]   mid_c, hi_c;
    logic            take_a;
    logic            seg_last;
    logic [PW-1:0]   lo_nx;
    logic [PW-1:0]   w_dbl;
    logic            out_last;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign full      = (r_count == CW'(MAX_ELEMENTS));
    assign cnt_after = full ? r_count : r_count + 1'b1;
    assign n_ext     = PW'(r_count);

    // Segment bounds, clamped to the set size
    always_comb begin
        mid_c = r_lo + r_w;
        if (mid_c > n_ext) begin
            mid_c = n_ext;
        end
        hi_c = mid_c + r_w;
        if (hi_c > n_ext) begin
            hi_c = n_ext;
        end
    end

    // Shared compare unit: run a wins if it has data and b is spent or not smaller
    assign src_a    = r_sel ? ram1_rd_a : ram0_rd_a;
    assign src_b    = r_sel ? ram1_rd_b : ram0_rd_b;
    assign take_a   = (r_a < r_mid) && ((r_b >= r_hi) || (src_a <= src_b));
    assign seg_last = ((r_k + 1'b1) == r_hi);
    assign lo_nx    = r_lo + (r_w << 1);
    assign w_dbl    = r_w << 1;
    assign out_last = ((r_k + 1'b1) == n_ext);

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_end_of_set) begin
                    n_state = (cnt_after > CW'(1)) ? S_SEG : S_OINIT;
                end
            end
            S_SEG:  n_state = S_MRD;
            S_MRD:  n_state = S_MCMP;
            S_MCMP: begin
                if (seg_last) begin
                    if (lo_nx >= n_ext && w_dbl >= n_ext) begin
                        n_state = S_OINIT;
                    end else begin
                        n_state = S_SEG;
                    end
                end else begin
                    n_state = S_MRD;
                end
            end
            S_OINIT: n_state = S_ORD;
            S_ORD:   n_state = S_OEMIT;
            S_OEMIT: n_state = out_last ? S_IDLE : S_ORD;
            default: n_state = S_IDLE;
        endcase
    end

    // ---- outputs and RAM control ----
    always_comb begin
        ram0_we    = 1'b0;
        ram1_we    = 1'b0;
        ram0_waddr = r_count[AW-1:0];
        ram1_waddr = r_k[AW-1:0];
        ram0_wdata = i_value;
        ram1_wdata = take_a ? src_a : src_b;
        raddr_a    = r_a[AW-1:0];
        raddr_b    = r_b[AW-1:0];
        o_strobe   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                ram0_we = accept && !full;
            end
            S_MCMP: begin
                // destination is the RAM that is not the source
                ram0_we    = r_sel;
                ram1_we    = !r_sel;
                ram0_waddr = r_k[AW-1:0];
                ram0_wdata = take_a ? src_a : src_b;
            end
            S_ORD: begin
                raddr_a = r_k[0] ? r_b[AW-1:0] : r_a[AW-1:0];
            end
            S_OEMIT: begin
                o_strobe = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_value_res      = src_a;
    assign o_end_of_set_res = o_strobe && out_last;
    assign o_overflow       = o_strobe && r_ovf;

    // ---- datapath next values ----
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_sel   = r_sel;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_a     = r_a;
        n_b     = r_b;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_count = cnt_after;
                    if (full) begin
                        n_ovf = 1'b1;
                    end
                    if (i_end_of_set) begin
                        n_w   = PW'(1);
                        n_lo  = '0;
                        n_sel = 1'b0;
                    end
                end
            end
            S_SEG: begin
                n_mid = mid_c;
                n_hi  = hi_c;
                n_a   = r_lo;
                n_b   = mid_c;
                n_k   = r_lo;
            end
            S_MCMP: begin
                n_k = r_k + 1'b1;
                if (take_a) begin
                    n_a = r_a + 1'b1;
                end else begin
                    n_b = r_b + 1'b1;
                end
                if (seg_last) begin
                    if (lo_nx >= n_ext) begin
                        // pass complete: swap roles, double run width
                        n_w   = w_dbl;
                        n_sel = ~r_sel;
                        n_lo  = '0;
                    end else begin
                        n_lo = lo_nx;
                    end
                end
            end
            S_OINIT: begin
                n_a = (n_ext - 1'b1) >> 1;
                n_b = n_ext - 1'b1;
                n_k = '0;
            end
            S_OEMIT: begin
                n_k = r_k + 1'b1;
                if (r_k[0]) begin
                    n_b = r_b - 1'b1;
                end else begin
                    n_a = r_a - 1'b1;
                end
                if (out_last) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_a   <= n_a;
        r_b   <= n_b;
        r_k   <= n_k;
    end

    // ---- ping-pong stores ----
    wse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (ram0_we),
        .i_waddr   (ram0_waddr),
        .i_wdata   (ram0_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (ram0_rd_a),
        .o_rdata_b (ram0_rd_b)
    );

    wse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (ram1_we),
        .i_waddr   (ram1_waddr),
        .i_wdata   (ram1_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (ram1_rd_a),
        .o_rdata_b (ram1_rd_b)
    );

    // ---- checks ----
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_end_of_set_res) |=> (!busy && r_count == '0 && !r_ovf))
        else $error("engine not released after final result");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS))
        else $error("element count beyond store depth");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> full)
        else $error("overflow flagged with free space");

endmodule : wiggle_sort_engine
`default_nettype wire

// ===== rtl/core/wse_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wse_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module wse_ram
    import wse_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = MAX_ELEMENTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule : wse_ram
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wiggle sort engine.
// ----------------------------------------------------------------------------
// Requests of signed values go in on start/busy and build sets. Each set is
// closed by a request with i_end_of_set high. A shadow model in the bench
// keeps its own copy of the set, sorts it and lays it out in wiggle order.
// Every strobed result is checked field by field against the oldest pending
// result.
// The run starts with a directed table: single-value sets of the extremes,
// equal values, and ascending, descending and mixed sets. Rows whose result
// is obvious carry it typed in. A random phase follows, with mostly short
// sets and a few full or overflowing ones, random values and random gaps.
// ----------------------------------------------------------------------------
module tb_top
    import wse_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = MAX_ELEMENTS_DEF;
    localparam int RAND_ITEMS  = 260;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 23;
    localparam int TAIL_CYCLES = 20;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    // One result of a wiggle run
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               ovf;
    } wiggle_res_t;

    // One row of the directed table. Where typed is set, the row closes a
    // one-value set and its single result is exp_value.
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               typed;
        logic signed [31:0] exp_value;
    } dir_row_t;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic signed [31:0] i_value      = '0;
    logic               i_end_of_set = 1'b0;
    logic               busy;
    logic               o_strobe;
    logic signed [31:0] o_value_res;
    logic               o_end_of_set_res;
    logic               o_overflow;

    // Typed-in expectation, driven alongside the request it belongs to
    logic               tbl_typed = 1'b0;
    logic signed [31:0] tbl_exp   = '0;

    int          held_vals[$];      // values of the set being loaded
    bit          held_dropped = 1'b0;
    wiggle_res_t pending_res[$];    // results still to come, oldest first
    int          err_cnt   = 0;
    int          cycle_cnt = 0;

    dir_row_t    dir_rows [DIR_ROWS];

    wiggle_sort_engine u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_value          (i_value),
        .i_end_of_set     (i_end_of_set),
        .o_strobe         (o_strobe),
        .o_value_res      (o_value_res),
        .o_end_of_set_res (o_end_of_set_res),
        .o_overflow       (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow model: store the value (or note the drop when the store is full);
    // on the last request queue the typed result or the set in wiggle order.
    // ------------------------------------------------------------------------
    task automatic absorb_request(input logic signed [31:0] v, input logic last,
                                  input logic typed, input logic signed [31:0] ev);
        int          srt[$];
        int          n, lo, hi, i, j, tmp;
        wiggle_res_t r;
        if (held_vals.size() < STORE_DEPTH)
            held_vals.push_back(v);
        else
            held_dropped = 1'b1;
        if (!last)
            return;
        if (typed) begin
            r.value = ev;
            r.last  = 1'b1;
            r.ovf   = 1'b0;
            pending_res.push_back(r);
        end else begin
            srt = held_vals;
            n   = srt.size();
            // insertion sort, ascending signed
            for (i = 1; i < n; i++) begin
                tmp = srt[i];
                j   = i - 1;
                while (j >= 0 && srt[j] > tmp) begin
                    srt[j + 1] = srt[j];
                    j--;
                end
                srt[j + 1] = tmp;
            end
            // even slots walk the lower half down, odd slots the upper half
            lo = (n - 1) / 2;
            hi = n - 1;
            for (i = 0; i < n; i++) begin
                if (i % 2 == 0) begin
                    r.value = srt[lo];
                    lo--;
                end else begin
                    r.value = srt[hi];
                    hi--;
                end
                r.last = (i == n - 1);
                r.ovf  = held_dropped;
                pending_res.push_back(r);
            end
        end
        held_vals.delete();
        held_dropped = 1'b0;
    endtask

    task automatic check_result();
        wiggle_res_t e;
        if (pending_res.size() == 0) begin
            $error("result with none pending: value_res=%0d", o_value_res);
            err_cnt++;
            return;
        end
        e = pending_res.pop_front();
        if (o_value_res !== e.value) begin
            $error("value_res: expected %0d, got %0d", e.value, o_value_res);
            err_cnt++;
        end
        if (o_end_of_set_res !== e.last) begin
            $error("end_of_set_res: expected %0b, got %0b", e.last, o_end_of_set_res);
            err_cnt++;
        end
        if (o_overflow !== e.ovf) begin
            $error("overflow: expected %0b, got %0b", e.ovf, o_overflow);
            err_cnt++;
        end
    endtask

    // Monitor: everything here reads values from before the edge. Results
    // and new requests never share an edge (busy is high during output).
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                check_result();
            if (start && !busy)
                absorb_request(i_value, i_end_of_set, tbl_typed, tbl_exp);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL wiggle_sort_engine");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------

    // Present one request and hold it until taken. start is raised here only;
    // a back-to-back request leaves it high, so it never toggles in one step.
    task automatic send_request(input logic signed [31:0] v, input logic last,
                                input logic typed, input logic signed [31:0] ev);
        i_value      <= v;
        i_end_of_set <= last;
        tbl_typed    <= typed;
        tbl_exp      <= ev;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drop start and hold off until every pending result has been seen.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_res.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 15);
        if (r < 8)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Set sizes: mostly small, a few near or past the store depth. A few
    // early sets are forced to hit exactly full and overflow (final dropped).
    function automatic int set_length(input int idx);
        int r;
        if (idx == 2)
            return STORE_DEPTH;
        if (idx == 5)
            return STORE_DEPTH + 2;
        if (idx == 9)
            return STORE_DEPTH + 1;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(STORE_DEPTH, STORE_DEPTH + 6);
        if (r == 1)
            return $urandom_range(13, STORE_DEPTH - 1);
        return $urandom_range(1, 12);
    endfunction

    // Full-range values, a narrow band to force ties, and the extremes
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                case ($urandom_range(0, 3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return $signed($urandom_range(0, 16)) - 32'sd8;
            default: return $signed($urandom());
        endcase
    endfunction

    initial begin
        int  row, sent, set_idx, len, k;
        bit  calm;

        dir_rows = '{
            // single-value sets: result is the value itself
            '{VAL_MIN,   1'b1, 1'b1, VAL_MIN},
            '{VAL_MAX,   1'b1, 1'b1, VAL_MAX},
            '{32'sd0,    1'b1, 1'b1, 32'sd0},
            '{-32'sd1,   1'b1, 1'b1, -32'sd1},
            // both extremes in one set
            '{VAL_MAX,   1'b0, 1'b0, 32'sd0},
            '{VAL_MIN,   1'b1, 1'b0, 32'sd0},
            // ties
            '{32'sd5,    1'b0, 1'b0, 32'sd0},
            '{32'sd5,    1'b0, 1'b0, 32'sd0},
            '{32'sd5,    1'b1, 1'b0, 32'sd0},
            // already ascending, odd size
            '{32'sd1,    1'b0, 1'b0, 32'sd0},
            '{32'sd2,    1'b0, 1'b0, 32'sd0},
            '{32'sd3,    1'b0, 1'b0, 32'sd0},
            '{32'sd4,    1'b0, 1'b0, 32'sd0},
            '{32'sd5,    1'b1, 1'b0, 32'sd0},
            // descending across zero, even size
            '{32'sd60,   1'b0, 1'b0, 32'sd0},
            '{32'sd50,   1'b0, 1'b0, 32'sd0},
            '{32'sd40,   1'b0, 1'b0, 32'sd0},
            '{-32'sd10,  1'b0, 1'b0, 32'sd0},
            '{-32'sd20,  1'b0, 1'b0, 32'sd0},
            '{-32'sd30,  1'b1, 1'b0, 32'sd0},
            // sign boundary mix
            '{VAL_MIN,   1'b0, 1'b0, 32'sd0},
            '{VAL_MAX,   1'b0, 1'b0, 32'sd0},
            '{-32'sd1,   1'b1, 1'b0, 32'sd0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, random gaps, none after every third row
        for (row = 0; row < DIR_ROWS; row++) begin
            send_request(dir_rows[row].value, dir_rows[row].last,
                         dir_rows[row].typed, dir_rows[row].exp_value);
            idle_gap(pick_gap(row % 3 == 0));
        end
        drain();

        // random sets; now and then hold off until the engine is empty
        sent    = 0;
        set_idx = 0;
        while (sent < RAND_ITEMS) begin
            len  = set_length(set_idx);
            calm = ($urandom_range(0, 2) == 0);
            if (set_idx == 4 || $urandom_range(0, 7) == 0)
                drain();
            for (k = 0; k < len; k++) begin
                send_request(pick_value(), (k == len - 1), 1'b0, 32'sd0);
                sent++;
                idle_gap(pick_gap(calm));
            end
            set_idx++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("PASS wiggle_sort_engine");
        else
            $display("FAIL wiggle_sort_engine");
        $finish;
    end

endmodule : tb_top
`default_nettype wire
